[design/irfe_pkg.sv]
// Package with the symbol codes, gap times and sequencer microcode of the IR frame encoder.
`timescale 1ns / 1ps
`default_nettype none

package irfe_pkg;

  localparam int unsigned MarkW  = 10;
  localparam int unsigned SpaceW = 14;
  localparam int unsigned FrameBits = 16;
  localparam int unsigned BitCntW = $clog2(FrameBits);
  localparam int unsigned PcW = 3;

  localparam logic [MarkW-1:0] MarkReset = MarkW'(200);

  localparam logic [SpaceW-1:0] GapStartShort = SpaceW'(3125);
  localparam logic [SpaceW-1:0] GapStartLong  = SpaceW'(15625);
  localparam logic [SpaceW-1:0] GapZero       = SpaceW'(3125);
  localparam logic [SpaceW-1:0] GapOne        = SpaceW'(9375);
  localparam logic [SpaceW-1:0] GapRepeat     = SpaceW'(6250);
  localparam logic [SpaceW-1:0] GapTrailer    = SpaceW'(12500);
  localparam logic [SpaceW-1:0] GapStop       = SpaceW'(1);

  typedef enum logic [2:0] {
    KIND_START   = 3'd0,
    KIND_ZERO    = 3'd1,
    KIND_ONE     = 3'd2,
    KIND_REPEAT  = 3'd3,
    KIND_TRAILER = 3'd4,
    KIND_STOP    = 3'd5
  } kind_e;

  typedef enum logic [0:0] {
    OP_FIXED = 1'b0,
    OP_BIT   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  localparam logic [PcW-1:0] PcStart0  = PcW'(0);
  localparam logic [PcW-1:0] PcStart1  = PcW'(1);
  localparam logic [PcW-1:0] PcStart2  = PcW'(2);
  localparam logic [PcW-1:0] PcStart3  = PcW'(3);
  localparam logic [PcW-1:0] PcBits    = PcW'(4);
  localparam logic [PcW-1:0] PcTrailer = PcW'(5);
  localparam logic [PcW-1:0] PcStop    = PcW'(6);

  typedef struct packed {
    op_e              op;
    kind_e            kind;
    logic [SpaceW-1:0] space;
    logic             last;
    logic             loop;
    logic [PcW-1:0]   loop_pc;
    logic             done;
  } uword_t;

  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    w = '{op: OP_FIXED, kind: KIND_STOP, space: GapStop, last: 1'b1,
          loop: 1'b0, loop_pc: PcStart0, done: 1'b1};
    case (pc)
      PcStart0: w = '{OP_FIXED, KIND_START, GapStartShort, 1'b0, 1'b0, PcStart0, 1'b0};
      PcStart1: w = '{OP_FIXED, KIND_START, GapStartShort, 1'b0, 1'b0, PcStart0, 1'b0};
      PcStart2: w = '{OP_FIXED, KIND_START, GapStartLong, 1'b0, 1'b0, PcStart0, 1'b0};
      PcStart3: w = '{OP_FIXED, KIND_START, GapStartShort, 1'b0, 1'b0, PcStart0, 1'b0};
      PcBits:   w = '{OP_BIT, KIND_REPEAT, GapRepeat, 1'b0, 1'b1, PcBits, 1'b0};
      PcTrailer: w = '{OP_FIXED, KIND_TRAILER, GapTrailer, 1'b0, 1'b0, PcStart0, 1'b0};
      PcStop:   w = '{OP_FIXED, KIND_STOP, GapStop, 1'b1, 1'b0, PcStart0, 1'b1};
      default:  w = '{OP_FIXED, KIND_STOP, GapStop, 1'b1, 1'b0, PcStart0, 1'b1};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[design/ir_remote_frame_encoder_top.sv]
// IR remote frame encoder: a microcoded sequencer that turns an address/command pair into 22 symbols.
// After an item is accepted, the state register enters run and the first symbol is then registered onto the output.
// Throughput: one symbol per cycle when the output is not stalled.
// The step counter walks a seven-word program; the data-bit word repeats 16 times.
// A new item is taken in the cycle the stop symbol is issued, so frames can run back to back.
// Reset (asynchronous, active low) idles the sequencer, empties the output and sets mark time to 200.
`timescale 1ns / 1ps
`default_nettype none

module ir_remote_frame_encoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wr_en_i,
  input  wire logic [9:0]  cfg_wr_data_i,    // mark_time_us
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [7:0] address, [15:8] command
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [9:0] mark_us, [23:10] space_us
  output logic [2:0]       m_axis_tuser_o,   // [2:0] symbol_kind
  output logic             m_axis_tlast_o    // last_symbol
);

  irfe_pkg::state_e                 state_q, state_d;
  logic [irfe_pkg::PcW-1:0]         pc_q, pc_d;
  logic [irfe_pkg::BitCntW-1:0]     cnt_q, cnt_d;
  logic [irfe_pkg::FrameBits-1:0]   shreg_q, shreg_d;
  logic                             prev_q, prev_d;
  logic [irfe_pkg::MarkW-1:0]       mark_q;
  logic                             ovalid_q, ovalid_d;
  irfe_pkg::kind_e                  okind_q, okind_d;
  logic [irfe_pkg::SpaceW-1:0]      ospace_q, ospace_d;
  logic [irfe_pkg::MarkW-1:0]       omark_q;
  logic                             olast_q, olast_d;

  irfe_pkg::uword_t uw;
  logic             step;
  logic             accept;
  logic             bit_cur;
  logic             cnt_end;

  assign uw      = irfe_pkg::ucode(pc_q);
  assign step    = (state_q == irfe_pkg::ST_RUN) && (!ovalid_q || m_axis_tready_i);
  assign bit_cur = shreg_q[irfe_pkg::FrameBits-1];
  assign cnt_end = (cnt_q == irfe_pkg::BitCntW'(irfe_pkg::FrameBits - 1));

  assign s_axis_tready_o = (state_q == irfe_pkg::ST_IDLE) || (step && uw.done);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d  = state_q;
    pc_d     = pc_q;
    cnt_d    = cnt_q;
    shreg_d  = shreg_q;
    prev_d   = prev_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    okind_d  = okind_q;
    ospace_d = ospace_q;
    olast_d  = olast_q;

    if (step) begin
      ovalid_d = 1'b1;
      okind_d  = uw.kind;
      ospace_d = uw.space;
      olast_d  = uw.last;
      if (uw.op == irfe_pkg::OP_BIT) begin
        if (bit_cur == prev_q) begin
          okind_d  = irfe_pkg::KIND_REPEAT;
          ospace_d = irfe_pkg::GapRepeat;
        end else if (bit_cur) begin
          okind_d  = irfe_pkg::KIND_ONE;
          ospace_d = irfe_pkg::GapOne;
        end else begin
          okind_d  = irfe_pkg::KIND_ZERO;
          ospace_d = irfe_pkg::GapZero;
        end
        prev_d  = bit_cur;
        shreg_d = {shreg_q[irfe_pkg::FrameBits-2:0], 1'b0};
        cnt_d   = cnt_q + irfe_pkg::BitCntW'(1);
      end
      if (uw.loop && !cnt_end) begin
        pc_d = uw.loop_pc;
      end else begin
        pc_d = pc_q + irfe_pkg::PcW'(1);
      end
      if (uw.done) begin
        state_d = irfe_pkg::ST_IDLE;
      end
    end

    if (accept) begin
      state_d = irfe_pkg::ST_RUN;
      pc_d    = irfe_pkg::PcStart0;
      cnt_d   = '0;
      prev_d  = 1'b0;
      shreg_d = {s_axis_tdata_i[7:0], s_axis_tdata_i[15:8]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= irfe_pkg::ST_IDLE;
      pc_q     <= irfe_pkg::PcStart0;
      cnt_q    <= '0;
      prev_q   <= 1'b0;
      ovalid_q <= 1'b0;
      mark_q   <= irfe_pkg::MarkReset;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      cnt_q    <= cnt_d;
      prev_q   <= prev_d;
      ovalid_q <= ovalid_d;
      if (cfg_wr_en_i) begin
        mark_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q  <= shreg_d;
    okind_q  <= okind_d;
    ospace_q <= ospace_d;
    olast_q  <= olast_d;
    if (step) begin
      omark_q <= mark_q;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {ospace_q, omark_q};
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tlast_o  = olast_q;

`ifndef SYNTHESIS
  a_last_is_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tuser_o == irfe_pkg::KIND_STOP))
    else $error("last symbol is not a stop symbol");

  a_cnt_idle_outside_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == irfe_pkg::ST_RUN && pc_q < irfe_pkg::PcBits) |-> (cnt_q == '0))
    else $error("bit counter moved before the data bits");

  a_accept_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == irfe_pkg::ST_RUN && pc_q == irfe_pkg::PcStart0 && !prev_q))
    else $error("accepted item did not restart the program");

  a_bits_done_leave_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && pc_q == irfe_pkg::PcBits && cnt_end) |=> (pc_q == irfe_pkg::PcTrailer))
    else $error("data bit loop did not exit after sixteen bits");
`endif

endmodule

`default_nettype wire

[dv/ir_remote_frame_encoder_top_tb.sv]
// Self-checking testbench for the IR remote frame encoder: 22-symbol frames checked against a predictor.
`timescale 1ns / 1ps

module ir_remote_frame_encoder_top_tb;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned N_DIRECTED = 16;
  localparam int unsigned N_RANDOM_PHASES = 6;
  localparam int unsigned ITEMS_PER_PHASE = 45;

  localparam logic [13:0] SP_START_SHORT = 14'd3125;
  localparam logic [13:0] SP_START_LONG  = 14'd15625;
  localparam logic [13:0] SP_ZERO        = 14'd3125;
  localparam logic [13:0] SP_ONE         = 14'd9375;
  localparam logic [13:0] SP_REPEAT      = 14'd6250;
  localparam logic [13:0] SP_TRAILER     = 14'd12500;
  localparam logic [13:0] SP_STOP        = 14'd1;

  typedef struct {
    irfe_pkg::kind_e kind;
    logic [9:0]      mark;
    logic [13:0]     space;
    logic            last;
  } symbol_t;

  typedef struct packed {
    logic            load;
    logic [9:0]      mark;
    logic [7:0]      addr;
    logic [7:0]      cmd;
    logic            typed;
    logic [9:0]      typed_mark;
    irfe_pkg::kind_e typed_first;
  } frame_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [9:0]  cfg_wr_data = '0;
  logic        s_valid = 1'b0;
  logic [15:0] s_data = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  symbol_t     pending_symbols[$];
  logic [9:0]  mark_time = 10'd200;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          sender_quiet = 1'b0;
  bit          sink_quiet = 1'b0;
  frame_row_t  directed_rows [N_DIRECTED];

  ir_remote_frame_encoder_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function void push_symbol(input irfe_pkg::kind_e kind, input logic [9:0] mark,
                            input logic [13:0] space, input logic last);
    symbol_t s;
    s.kind = kind;
    s.mark = mark;
    s.space = space;
    s.last = last;
    pending_symbols.push_back(s);
  endfunction

  // Each data bit is coded against the previous one, which is 0 at the start of a frame.
  function void encode_frame(input logic [7:0] addr, input logic [7:0] cmd,
                             input logic [9:0] mark);
    logic [15:0] bits;
    logic        prev;
    int          i;
    bits = {addr, cmd};
    prev = 1'b0;
    push_symbol(irfe_pkg::KIND_START, mark, SP_START_SHORT, 1'b0);
    push_symbol(irfe_pkg::KIND_START, mark, SP_START_SHORT, 1'b0);
    push_symbol(irfe_pkg::KIND_START, mark, SP_START_LONG, 1'b0);
    push_symbol(irfe_pkg::KIND_START, mark, SP_START_SHORT, 1'b0);
    for (i = 15; i >= 0; i--) begin
      if (bits[i] == prev) begin
        push_symbol(irfe_pkg::KIND_REPEAT, mark, SP_REPEAT, 1'b0);
      end else if (bits[i]) begin
        push_symbol(irfe_pkg::KIND_ONE, mark, SP_ONE, 1'b0);
      end else begin
        push_symbol(irfe_pkg::KIND_ZERO, mark, SP_ZERO, 1'b0);
      end
      prev = bits[i];
    end
    push_symbol(irfe_pkg::KIND_TRAILER, mark, SP_TRAILER, 1'b0);
    push_symbol(irfe_pkg::KIND_STOP, mark, SP_STOP, 1'b1);
  endfunction

  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_mark(input logic [9:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk_i);
    cfg_wr_en <= 1'b0;
    mark_time = value;
  endtask

  // Valid is only lowered when a gap follows or the stream is drained, so back-to-back items keep it high.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd, input bit typed,
                            input logic [9:0] typed_mark, input irfe_pkg::kind_e typed_first);
    int unsigned gap;
    gap = pick_gap(sender_quiet);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {cmd, addr};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (typed) begin
      encode_frame(addr, cmd, typed_mark);
      pending_symbols[pending_symbols.size() - 18].kind = typed_first;
    end else begin
      encode_frame(addr, cmd, mark_time);
    end
  endtask

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'hAA;
      3: return 8'h55;
      4: return 8'(1 << $urandom_range(0, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned p;
    int unsigned n;
    logic [9:0]  next_mark;
    directed_rows = '{
      '{1'b0, 10'd0,    8'h00, 8'h00, 1'b1, 10'd200,  irfe_pkg::KIND_REPEAT},
      '{1'b0, 10'd0,    8'hFF, 8'hFF, 1'b1, 10'd200,  irfe_pkg::KIND_ONE},
      '{1'b0, 10'd0,    8'h80, 8'h00, 1'b1, 10'd200,  irfe_pkg::KIND_ONE},
      '{1'b0, 10'd0,    8'h7F, 8'hFF, 1'b1, 10'd200,  irfe_pkg::KIND_REPEAT},
      '{1'b0, 10'd0,    8'hAA, 8'h55, 1'b0, 10'd0,    irfe_pkg::KIND_START},
      '{1'b0, 10'd0,    8'h55, 8'hAA, 1'b0, 10'd0,    irfe_pkg::KIND_START},
      '{1'b1, 10'd1023, 8'h01, 8'h80, 1'b1, 10'd1023, irfe_pkg::KIND_REPEAT},
      '{1'b0, 10'd0,    8'h00, 8'h01, 1'b1, 10'd1023, irfe_pkg::KIND_REPEAT},
      '{1'b0, 10'd0,    8'hFF, 8'h00, 1'b1, 10'd1023, irfe_pkg::KIND_ONE},
      '{1'b1, 10'd0,    8'h12, 8'h34, 1'b1, 10'd0,    irfe_pkg::KIND_REPEAT},
      '{1'b0, 10'd0,    8'hC3, 8'h3C, 1'b1, 10'd0,    irfe_pkg::KIND_ONE},
      '{1'b1, 10'd1,    8'hF0, 8'h0F, 1'b1, 10'd1,    irfe_pkg::KIND_ONE},
      '{1'b0, 10'd0,    8'h0F, 8'hF0, 1'b1, 10'd1,    irfe_pkg::KIND_REPEAT},
      '{1'b1, 10'd512,  8'h5A, 8'hA5, 1'b0, 10'd0,    irfe_pkg::KIND_START},
      '{1'b0, 10'd0,    8'hA5, 8'h5A, 1'b0, 10'd0,    irfe_pkg::KIND_START},
      '{1'b0, 10'd0,    8'hFE, 8'h01, 1'b0, 10'd0,    irfe_pkg::KIND_START}
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < N_DIRECTED; n++) begin
      if (directed_rows[n].load) begin
        load_mark(directed_rows[n].mark);
      end
      send_frame(directed_rows[n].addr, directed_rows[n].cmd, directed_rows[n].typed,
                 directed_rows[n].typed_mark, directed_rows[n].typed_first);
    end

    for (p = 0; p < N_RANDOM_PHASES; p++) begin
      case (p)
        0: next_mark = 10'd1023;
        1: next_mark = 10'd1;
        2: next_mark = 10'd0;
        default: next_mark = 10'($urandom_range(1, 1023));
      endcase
      load_mark(next_mark);
      sender_quiet = (p == 1);
      sink_quiet = (p == 3);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_frame(random_byte(), random_byte(), 1'b0, 10'd0, irfe_pkg::KIND_START);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_ready <= 1'b0;
    end else if (sink_quiet || $urandom_range(0, 3) != 0) begin
      m_ready <= 1'b1;
    end else begin
      stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      m_ready <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    symbol_t want;
    if (m_axis_tvalid_o && m_ready) begin
      if (pending_symbols.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected symbol: expected none, actual kind %0d space %0d", $time,
                 m_axis_tuser_o, m_axis_tdata_o[23:10]);
      end else begin
        want = pending_symbols.pop_front();
        if (m_axis_tuser_o !== want.kind) begin
          mismatches++;
          $display("%0t: symbol_kind expected %0d actual %0d", $time, want.kind,
                   m_axis_tuser_o);
        end
        if (m_axis_tdata_o[9:0] !== want.mark) begin
          mismatches++;
          $display("%0t: mark_us expected %0d actual %0d", $time, want.mark,
                   m_axis_tdata_o[9:0]);
        end
        if (m_axis_tdata_o[23:10] !== want.space) begin
          mismatches++;
          $display("%0t: space_us expected %0d actual %0d", $time, want.space,
                   m_axis_tdata_o[23:10]);
        end
        if (m_axis_tlast_o !== want.last) begin
          mismatches++;
          $display("%0t: last_symbol expected %0d actual %0d", $time, want.last,
                   m_axis_tlast_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
